// ----- src/lcc_pkg.sv -----
package lcc_pkg;

    localparam int IN_W       = 54;
    localparam int NDIG       = 17;
    localparam int BCD_W      = 4 * NDIG;
    localparam int CNT_W      = $clog2(IN_W);
    localparam int IDX_W      = $clog2(NDIG);
    localparam int DCNT_W     = 5;
    localparam int MAX_DIGITS = 16;

    localparam logic [DCNT_W-1:0] LEN_13 = DCNT_W'(13);
    localparam logic [DCNT_W-1:0] LEN_15 = DCNT_W'(15);
    localparam logic [DCNT_W-1:0] LEN_16 = DCNT_W'(16);
    localparam logic [DCNT_W-1:0] LEN_MAX = DCNT_W'(MAX_DIGITS);

    localparam logic [3:0] DIG_1 = 4'd1;
    localparam logic [3:0] DIG_3 = 4'd3;
    localparam logic [3:0] DIG_4 = 4'd4;
    localparam logic [3:0] DIG_5 = 4'd5;
    localparam logic [3:0] DIG_7 = 4'd7;

    typedef enum logic [1:0] {
        CLS_INVALID = 2'd0,
        CLS_PFX_3X  = 2'd1,
        CLS_PFX_5X  = 2'd2,
        CLS_PFX_4   = 2'd3
    } t_class;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

// ----- src/lcc_req_if.sv -----
interface lcc_req_if;
    logic                     valid;
    logic                     ready;
    logic [lcc_pkg::IN_W-1:0] card_number;

    modport source(output valid, output card_number, input ready);
    modport sink(input valid, input card_number, output ready);
endinterface

// ----- src/lcc_rsp_if.sv -----
interface lcc_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 card_class;
    logic [lcc_pkg::DCNT_W-1:0] digit_count;
    logic                       checksum_ok;

    modport source(output valid, output card_class, output digit_count, output checksum_ok,
                   input ready);
    modport sink(input valid, input card_class, input digit_count, input checksum_ok,
                 output ready);
endinterface

// ----- src/luhn_card_classifier_unit.sv -----
// A request passes through bit-serial binary-to-BCD conversion, then a
// one-digit-per-cycle Luhn scan of the 17 BCD digits, then hand-off to the
// output register. A new request is taken only after the previous result is
// handed off; it may be taken while that result waits in the output register.
// Reset: synchronous active-low i_rst_n clears the sequencer and output valid.
module luhn_card_classifier_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    lcc_req_if.sink   i_req,
    lcc_rsp_if.source o_rsp
);

    lcc_pkg::t_state r_state;
    lcc_pkg::t_state n_state;

    logic                       start;
    logic                       conv_done;
    logic [lcc_pkg::BCD_W-1:0]  conv_bcd;
    logic                       out_load;

    logic [lcc_pkg::BCD_W-1:0]  r_digits;
    logic [lcc_pkg::IDX_W-1:0]  r_idx;
    logic [3:0]                 r_acc;
    logic [lcc_pkg::DCNT_W-1:0] r_count;
    logic [3:0]                 r_lead;
    logic [3:0]                 r_second;
    logic [3:0]                 r_prev;

    logic                       r_out_valid;
    logic [1:0]                 r_out_class;
    logic [lcc_pkg::DCNT_W-1:0] r_out_count;
    logic                       r_out_ok;

    logic [3:0] dig;
    logic [4:0] dbl;
    logic [4:0] wdig;
    logic [4:0] sum;
    logic       ok;
    logic       len_ok;
    lcc_pkg::t_class cls;

    lcc_bin2bcd u_bin2bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_value (i_req.card_number),
        .o_done  (conv_done),
        .o_bcd   (conv_bcd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        start       = 1'b0;
        out_load    = 1'b0;
        i_req.ready = 1'b0;
        unique case (r_state)
            lcc_pkg::ST_IDLE: begin
                i_req.ready = i_rst_n;
                if (i_req.valid && i_rst_n) begin
                    start   = 1'b1;
                    n_state = lcc_pkg::ST_CONV;
                end
            end
            lcc_pkg::ST_CONV: begin
                if (conv_done) begin
                    n_state = lcc_pkg::ST_SCAN;
                end
            end
            lcc_pkg::ST_SCAN: begin
                if (r_idx == lcc_pkg::IDX_W'(lcc_pkg::NDIG - 1)) begin
                    n_state = lcc_pkg::ST_DONE;
                end
            end
            lcc_pkg::ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = lcc_pkg::ST_IDLE;
                end
            end
            default: n_state = lcc_pkg::ST_IDLE;
        endcase
    end

    // Luhn weighting of the current digit, running sum kept mod 10
    always_comb begin
        dig  = r_digits[3:0];
        dbl  = {dig, 1'b0};
        wdig = r_idx[0] ? ((dbl >= 5'd10) ? dbl - 5'd9 : dbl) : {1'b0, dig};
        sum  = {1'b0, r_acc} + wdig;
    end

    always_ff @(posedge i_clk) begin
        if (conv_done) begin
            r_digits <= conv_bcd;
            r_idx    <= '0;
            r_acc    <= '0;
            r_count  <= lcc_pkg::DCNT_W'(1);
            r_lead   <= '0;
            r_second <= '0;
            r_prev   <= '0;
        end else if (r_state == lcc_pkg::ST_SCAN) begin
            r_digits <= {4'd0, r_digits[lcc_pkg::BCD_W-1:4]};
            r_idx    <= r_idx + 1'b1;
            r_acc    <= (sum >= 5'd10) ? 4'(sum - 5'd10) : sum[3:0];
            r_prev   <= dig;
            if (dig != 4'd0) begin
                r_count  <= lcc_pkg::DCNT_W'(r_idx) + lcc_pkg::DCNT_W'(1);
                r_lead   <= dig;
                r_second <= r_prev;
            end
        end
    end

    always_comb begin
        ok     = (r_acc == 4'd0);
        len_ok = (r_count == lcc_pkg::LEN_13) || (r_count == lcc_pkg::LEN_15)
              || (r_count == lcc_pkg::LEN_16);
        cls    = lcc_pkg::CLS_INVALID;
        if (ok && len_ok && (r_count <= lcc_pkg::LEN_MAX)) begin
            if (r_lead == lcc_pkg::DIG_3 &&
                (r_second == lcc_pkg::DIG_4 || r_second == lcc_pkg::DIG_7)) begin
                cls = lcc_pkg::CLS_PFX_3X;
            end else if (r_lead == lcc_pkg::DIG_5 && r_second >= lcc_pkg::DIG_1 &&
                         r_second <= lcc_pkg::DIG_5) begin
                cls = lcc_pkg::CLS_PFX_5X;
            end else if (r_lead == lcc_pkg::DIG_4) begin
                cls = lcc_pkg::CLS_PFX_4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_class <= cls;
            r_out_count <= r_count;
            r_out_ok    <= ok;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.card_class  = r_out_class;
    assign o_rsp.digit_count = r_out_count;
    assign o_rsp.checksum_ok = r_out_ok;

endmodule

// ----- src/lcc_bin2bcd.sv -----
module lcc_bin2bcd (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [lcc_pkg::IN_W-1:0]  i_value,
    output logic                      o_done,
    output logic [lcc_pkg::BCD_W-1:0] o_bcd
);

    logic [lcc_pkg::IN_W-1:0]  r_bin;
    logic [lcc_pkg::BCD_W-1:0] r_bcd;
    logic [lcc_pkg::CNT_W-1:0] r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [lcc_pkg::BCD_W-1:0] adj;

    // shift-and-add-3, one input bit per cycle
    always_comb begin
        for (int k = 0; k < lcc_pkg::NDIG; k++) begin
            adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? r_bcd[4*k +: 4] + 4'd3
                                                       : r_bcd[4*k +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == lcc_pkg::CNT_W'(lcc_pkg::IN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[lcc_pkg::IN_W-2:0], 1'b0};
            r_bcd <= {adj[lcc_pkg::BCD_W-2:0], r_bin[lcc_pkg::IN_W-1]};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule
